// File: rtl/core/taes3_pkg.sv
`default_nettype none

package taes3_pkg;

    localparam int ROUNDS    = 3;
    localparam int NUM_KEYS  = 4;
    localparam int NUM_REGS  = 2 * NUM_KEYS;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int APB_AW    = REG_IDX_W + 3;
    localparam int APB_DW    = 64;
    localparam int BLK_W     = 128;

    typedef enum logic
    {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t     opcode;
        logic [63:0] block_lo;
        logic [63:0] block_hi;
        logic [63:0] tweak_lo;
        logic [63:0] tweak_hi;
    } blk_item_t;

    typedef struct packed
    {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
    } res_item_t;

    typedef logic [BLK_W-1:0] state_t;
    typedef logic [NUM_KEYS-1:0][BLK_W-1:0] key_set_t;

    localparam logic [0:255][7:0] SBOX = {
        256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
        256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
        256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
        256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
        256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
        256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
        256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
        256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:255][7:0] INV_SBOX = {
        256'h52096ad53036a538bf40a39e81f3d7fb7ce339829b2fff87348e4344c4dee9cb,
        256'h547b9432a6c2233dee4c950b42fac34e082ea16628d924b2765ba2496d8bd125,
        256'h72f8f66486689816d4a45ccc5d65b6926c704850fdedb9da5e154657a78d9d84,
        256'h90d8ab008cbcd30af7e45805b8b34506d02c1e8fca3f0f02c1afbd0301138a6b,
        256'h3a9111414f67dcea97f2cfcef0b4e67396ac7422e7ad3585e2f937e81c75df6e,
        256'h47f11a711d29c5896fb7620eaa18be1bfc563e4bc6d279209adbc0fe78cd5af4,
        256'h1fdda8338807c731b11210592780ec5f60517fa919b54a0d2de57a9f93c99cef,
        256'ha0e03b4dae2af5b0c8ebbb3c83539961172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes, ShiftRows and MixColumns
    function automatic state_t enc_round(input state_t s);
        state_t     t;
        state_t     o;
        logic [7:0] col [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r) & 3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                col[r] = t[8*(r+4*c) +: 8];
            end
            for (int r = 0; r < 4; r++)
            begin
                o[8*(r+4*c) +: 8] = xtime(col[r]) ^ xtime(col[(r+1) & 3]) ^ col[(r+1) & 3]
                                    ^ col[(r+2) & 3] ^ col[(r+3) & 3];
            end
        end
        return o;
    endfunction

    // InvMixColumns, then InvShiftRows and InvSubBytes
    function automatic state_t dec_round(input state_t s);
        state_t     o;
        logic [7:0] x1 [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                x1[r] = s[8*(r+4*c) +: 8];
                x2[r] = xtime(x1[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            for (int r = 0; r < 4; r++)
            begin
                m = (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r+1) & 3] ^ x2[(r+1) & 3] ^ x1[(r+1) & 3])
                    ^ (x8[(r+2) & 3] ^ x4[(r+2) & 3] ^ x1[(r+2) & 3])
                    ^ (x8[(r+3) & 3] ^ x1[(r+3) & 3]);
                o[8*(r+4*((c+r) & 3)) +: 8] = INV_SBOX[m];
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/taes3_cfg_regs.sv
`default_nettype none

module taes3_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [taes3_pkg::APB_AW-1:0]       paddr,
    input  wire logic [taes3_pkg::APB_DW-1:0]       pwdata,
    output logic      [taes3_pkg::APB_DW-1:0]       prdata,
    output logic                                    pready,
    output taes3_pkg::key_set_t                     keys
);

    logic [taes3_pkg::APB_DW-1:0] key_reg [taes3_pkg::NUM_REGS];
    logic [taes3_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[taes3_pkg::APB_AW-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = key_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < taes3_pkg::NUM_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            key_reg[idx] <= pwdata;
        end
    end

    // low half of each key sits at the even register
    always_comb
    begin
        for (int k = 0; k < taes3_pkg::NUM_KEYS; k++)
        begin
            keys[k] = {key_reg[2*k+1], key_reg[2*k]};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/taes3_rounds.sv
`default_nettype none

module taes3_rounds
#(
    parameter int ROUNDS = taes3_pkg::ROUNDS
)
(
    input  wire taes3_pkg::blk_item_t item,
    input  wire taes3_pkg::key_set_t  keys,
    output taes3_pkg::res_item_t      res
);

    taes3_pkg::state_t tweak;
    taes3_pkg::state_t rk      [taes3_pkg::NUM_KEYS];
    taes3_pkg::state_t enc_st  [ROUNDS+1];
    taes3_pkg::state_t dec_st  [ROUNDS+1];
    taes3_pkg::state_t result;

    assign tweak = {item.tweak_hi, item.tweak_lo};

    genvar k;
    generate
        for (k = 0; k < taes3_pkg::NUM_KEYS; k++)
        begin : g_rk
            assign rk[k] = keys[k] ^ tweak;
        end
    endgenerate

    assign enc_st[0]      = {item.block_hi, item.block_lo} ^ rk[0];
    assign dec_st[ROUNDS] = {item.block_hi, item.block_lo};

    // rounds past the last key reuse the last key
    genvar r;
    generate
        for (r = 1; r <= ROUNDS; r++)
        begin : g_round
            localparam int KI = (r < taes3_pkg::NUM_KEYS) ? r : taes3_pkg::NUM_KEYS - 1;
            assign enc_st[r]   = taes3_pkg::enc_round(enc_st[r-1]) ^ rk[KI];
            assign dec_st[r-1] = taes3_pkg::dec_round(dec_st[r] ^ rk[KI]);
        end
    endgenerate

    assign result = (item.opcode == taes3_pkg::OP_DEC) ? (dec_st[0] ^ rk[0])
                                                         : enc_st[ROUNDS];

    assign res.result_lo = result[63:0];
    assign res.result_hi = result[127:64];

endmodule

`default_nettype wire

// File: rtl/core/tweaked_aes3_round_cipher.sv
`default_nettype none

// Channel | Direction | Handshake             | Payload
// blk     | in        | blk_valid / blk_ready | blk_data  (opcode, block, tweak)
// res     | out       | res_valid / res_ready | res_data  (result)
// apb     | in        | psel/penable/pwrite   | paddr, pwdata, prdata (round keys)
//
// One block per cycle while the result side is not stalled. A block passes through
// the input register, then the result register, before its result is valid and
// can transfer. All rounds sit in one combinational path between the two, so the
// depth of that path grows with the round count.
// Reset clears the valid flags and the round keys. A stalled result holds in
// the result register while an empty input register still takes one more block.

module tweaked_aes3_round_cipher
#(
    parameter int ROUNDS = taes3_pkg::ROUNDS
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               blk_valid,
    output logic                                    blk_ready,
    input  wire taes3_pkg::blk_item_t               blk_data,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output taes3_pkg::res_item_t                    res_data,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [taes3_pkg::APB_AW-1:0]       paddr,
    input  wire logic [taes3_pkg::APB_DW-1:0]       pwdata,
    output logic      [taes3_pkg::APB_DW-1:0]       prdata,
    output logic                                    pready
);

    taes3_pkg::key_set_t  keys;
    taes3_pkg::blk_item_t s1_reg;
    taes3_pkg::res_item_t s2_reg;
    taes3_pkg::res_item_t s2_next;
    logic v1_reg;
    logic v2_reg;
    logic s1_en;
    logic s2_en;

    taes3_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keys    (keys)
    );

    taes3_rounds
    #(
        .ROUNDS (ROUNDS)
    )
    u_rounds
    (
        .item (s1_reg),
        .keys (keys),
        .res  (s2_next)
    );

    // advance each stage when it is empty or the one after it is empty or draining
    assign s2_en     = !v2_reg || res_ready;
    assign s1_en     = !v1_reg || s2_en;
    assign blk_ready = s1_en;
    assign res_valid = v2_reg;
    assign res_data  = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                v1_reg <= blk_valid;
            end
            if (s2_en)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && blk_valid)
        begin
            s1_reg <= blk_data;
        end
        if (s2_en && v1_reg)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/taes3_checker.sv
`default_nettype none

module taes3_checker
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 blk_valid,
    input wire logic                 blk_ready,
    input wire logic                 res_valid,
    input wire logic                 res_ready,
    input wire taes3_pkg::res_item_t res_data
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // no backpressure on the input while the output side is empty or draining
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ready || !res_valid) |-> blk_ready)
        else $error("input stalled while output side is free");

    // a result from an empty pipe needs a matching earlier input transfer
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(blk_valid && blk_ready, 2))
        else $error("result appeared without a matching input transfer");

endmodule

bind tweaked_aes3_round_cipher taes3_checker u_taes3_checker (.*);

`default_nettype wire

// File: verif/tweaked_aes3_round_cipher_test.sv
`default_nettype none

module tweaked_aes3_round_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 195;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_WAIT     = 18;
    localparam int ADDR_W       = taes3_pkg::APB_AW;
    localparam int DATA_W       = taes3_pkg::APB_DW;
    localparam int NUM_REGS     = taes3_pkg::NUM_REGS;
    localparam int NUM_KEYS     = taes3_pkg::NUM_KEYS;

    localparam logic [127:0] ONES  = '1;
    localparam logic [127:0] BYTES = 128'h0f0e0d0c_0b0a0908_07060504_03020100;
    localparam logic [127:0] REV   = 128'h00010203_04050607_08090a0b_0c0d0e0f;
    localparam logic [127:0] ALT5  = 128'h55555555_55555555_55555555_55555555;
    localparam logic [127:0] ALTA  = 128'haaaaaaaa_aaaaaaaa_aaaaaaaa_aaaaaaaa;
    localparam logic [127:0] TOP   = 128'h80000000_00000000_00000000_00000000;

    typedef struct packed
    {
        taes3_pkg::opcode_t op;
        logic [127:0]       blk;
        logic [127:0]       twk;
    } vector_t;

    localparam int NUM_VECTORS = 14;
    localparam vector_t VECTORS [NUM_VECTORS] = '{
        '{taes3_pkg::OP_ENC, 128'h0,  128'h0},
        '{taes3_pkg::OP_DEC, 128'h0,  128'h0},
        '{taes3_pkg::OP_ENC, ONES,    ONES},
        '{taes3_pkg::OP_DEC, ONES,    ONES},
        '{taes3_pkg::OP_ENC, ONES,    128'h0},
        '{taes3_pkg::OP_DEC, 128'h0,  ONES},
        '{taes3_pkg::OP_ENC, BYTES,   128'h0},
        '{taes3_pkg::OP_DEC, BYTES,   REV},
        '{taes3_pkg::OP_ENC, ALT5,    ALTA},
        '{taes3_pkg::OP_DEC, ALTA,    ALT5},
        '{taes3_pkg::OP_ENC, 128'h1,  128'h0},
        '{taes3_pkg::OP_ENC, TOP,     128'h0},
        '{taes3_pkg::OP_ENC, 128'h0,  128'h1},
        '{taes3_pkg::OP_DEC, TOP,     TOP}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 blk_valid = 1'b0;
    logic                 blk_ready;
    taes3_pkg::blk_item_t blk_data  = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    taes3_pkg::res_item_t res_data;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_W-1:0]    paddr     = '0;
    logic [DATA_W-1:0]    pwdata    = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    logic [7:0]           sub_lut     [256];
    logic [7:0]           inv_sub_lut [256];
    logic [63:0]          key_regs    [NUM_REGS];
    taes3_pkg::res_item_t expected_q  [$];

    int fail_count   = 0;
    int result_count = 0;
    int enc_count    = 0;
    int dec_count    = 0;
    int cycle_count  = 0;
    int stall_level  = 0;

    tweaked_aes3_round_cipher dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // S-box from the field inverse and the affine map, so no table is shared with the block
    function automatic void build_sbox();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
            begin
                if (gf_mul(8'(x), 8'(y)) == 8'h01)
                    inv = 8'(y);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_lut[x]     = s;
            inv_sub_lut[s] = 8'(x);
        end
    endfunction

    function automatic logic [127:0] fwd_round(input logic [127:0] s);
        logic [127:0] t;
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[8*(r+4*c) +: 8] = sub_lut[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a0 = t[8*(4*c+r) +: 8];
                a1 = t[8*(4*c+(r+1)%4) +: 8];
                a2 = t[8*(4*c+(r+2)%4) +: 8];
                a3 = t[8*(4*c+(r+3)%4) +: 8];
                o[8*(4*c+r) +: 8] = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_round(input logic [127:0] s);
        logic [127:0] t;
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a0 = s[8*(4*c+r) +: 8];
                a1 = s[8*(4*c+(r+1)%4) +: 8];
                a2 = s[8*(4*c+(r+2)%4) +: 8];
                a3 = s[8*(4*c+(r+3)%4) +: 8];
                t[8*(4*c+r) +: 8] = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b)
                                    ^ gf_mul(a2, 8'h0d) ^ gf_mul(a3, 8'h09);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[8*(r+4*((c+r)%4)) +: 8] = inv_sub_lut[t[8*(r+4*c) +: 8]];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] round_key(input int k);
        return {key_regs[2*k+1], key_regs[2*k]};
    endfunction

    function automatic taes3_pkg::res_item_t transform_block(input taes3_pkg::blk_item_t item);
        logic [127:0]         st;
        logic [127:0]         tw;
        taes3_pkg::res_item_t res;
        int                   k;
        st = {item.block_hi, item.block_lo};
        tw = {item.tweak_hi, item.tweak_lo};
        if (item.opcode == taes3_pkg::OP_ENC)
        begin
            st ^= round_key(0) ^ tw;
            for (int r = 1; r <= taes3_pkg::ROUNDS; r++)
            begin
                // rounds past the last key reuse it
                k  = (r < NUM_KEYS) ? r : NUM_KEYS - 1;
                st = fwd_round(st) ^ round_key(k) ^ tw;
            end
        end
        else
        begin
            for (int r = taes3_pkg::ROUNDS; r >= 1; r--)
            begin
                k  = (r < NUM_KEYS) ? r : NUM_KEYS - 1;
                st = inv_round(st ^ round_key(k) ^ tw);
            end
            st ^= round_key(0) ^ tw;
        end
        res.result_lo = st[63:0];
        res.result_hi = st[127:64];
        return res;
    endfunction

    function automatic int draw_wait();
        case (stall_level)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
            default: return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_key_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input taes3_pkg::blk_item_t item);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            blk_valid <= 1'b0;
        end
        @(negedge clk);
        blk_valid <= 1'b1;
        blk_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!blk_ready);
        expected_q.push_back(transform_block(item));
        if (item.opcode == taes3_pkg::OP_ENC)
            enc_count++;
        else
            dec_count++;
    endtask

    // drop valid and hold until every outstanding result has been taken
    task automatic finish_burst();
        @(negedge clk);
        blk_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key_reg(input int idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        key_regs[idx] = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_key_reg(input int idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 8);
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== key_regs[idx])
        begin
            $error("prdata (key register %0d): expected %h, got %h",
                   idx, key_regs[idx], prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : result_sink
        int                   hold;
        taes3_pkg::res_item_t want;
        hold = draw_wait();
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_ready <= 1'b0;
                hold--;
            end
            else
                res_ready <= 1'b1;
            @(posedge clk);
            if (res_valid && res_ready)
            begin
                result_count++;
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no block outstanding: %h", res_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res_data.result_lo !== want.result_lo)
                    begin
                        $error("result_lo: expected %h, got %h",
                               want.result_lo, res_data.result_lo);
                        fail_count++;
                    end
                    if (res_data.result_hi !== want.result_hi)
                    begin
                        $error("result_hi: expected %h, got %h",
                               want.result_hi, res_data.result_hi);
                        fail_count++;
                    end
                end
                hold = draw_wait();
            end
        end
    end

    initial
    begin : stimulus
        taes3_pkg::blk_item_t item;
        taes3_pkg::blk_item_t prev;
        taes3_pkg::res_item_t prev_out;
        logic                 have_prev;
        int                   settings;
        build_sbox();
        foreach (key_regs[i])
            key_regs[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // keys must read back as zero out of reset
        for (int i = 0; i < NUM_REGS; i++)
            check_key_reg(i);
        settings = 1;

        // directed vectors, first under reset keys, then with every key bit set
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    write_key_reg(i, '1);
                    check_key_reg(i);
                end
                settings++;
            end
            stall_level = 2 * pass;
            for (int v = 0; v < NUM_VECTORS; v++)
            begin
                item.opcode   = VECTORS[v].op;
                item.block_lo = VECTORS[v].blk[63:0];
                item.block_hi = VECTORS[v].blk[127:64];
                item.tweak_lo = VECTORS[v].twk[63:0];
                item.tweak_hi = VECTORS[v].twk[127:64];
                send_block(item);
            end
            finish_burst();
        end

        have_prev = 1'b0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                write_key_reg(i, pick_key_word());
                check_key_reg(i);
            end
            settings++;
            have_prev   = 1'b0;
            stall_level = ph % 3;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (have_prev && $urandom_range(0, 5) == 0)
                begin
                    // feed the last output back through the opposite direction
                    prev_out      = transform_block(prev);
                    item.opcode   = (prev.opcode == taes3_pkg::OP_ENC) ? taes3_pkg::OP_DEC
                                                                       : taes3_pkg::OP_ENC;
                    item.block_lo = prev_out.result_lo;
                    item.block_hi = prev_out.result_hi;
                    item.tweak_lo = prev.tweak_lo;
                    item.tweak_hi = prev.tweak_hi;
                end
                else
                begin
                    item.opcode   = ($urandom_range(0, 1) == 1) ? taes3_pkg::OP_DEC
                                                                : taes3_pkg::OP_ENC;
                    item.block_lo = pick_word();
                    item.block_hi = pick_word();
                    item.tweak_lo = pick_word();
                    item.tweak_hi = pick_word();
                end
                send_block(item);
                prev      = item;
                have_prev = 1'b1;
                if ($urandom_range(0, 99) == 0)
                    finish_burst();
            end
            finish_burst();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
                 enc_count + dec_count, enc_count, dec_count, settings);
        $display("checked %0d results and every key register read-back.", result_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/taes3_pkg.sv
rtl/core/taes3_cfg_regs.sv
rtl/core/taes3_rounds.sv
rtl/core/tweaked_aes3_round_cipher.sv
rtl/core/taes3_checker.sv
verif/tweaked_aes3_round_cipher_test.sv
